// ----- rtl/core/tile_data_packet_framer_defines.svh -----
// Assertion macros shared by the framer RTL.
`ifndef TILE_DATA_PACKET_FRAMER_DEFINES_SVH
`define TILE_DATA_PACKET_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TDPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TDPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tdpf_pkg.sv -----
// Types and constants for the tile data packet framer.
`default_nettype none

package tdpf_pkg;

  localparam int unsigned POS_W = 10;
  localparam int unsigned SUM_W = 16;

  localparam int unsigned TILES_PER_PKT  = 40;
  localparam int unsigned BYTES_PER_TILE = 16;
  localparam logic [POS_W-1:0] PKT_DATA_BYTES = POS_W'(TILES_PER_PKT * BYTES_PER_TILE);

  localparam logic [7:0] SYNC_BYTE_A   = 8'h88;
  localparam logic [7:0] SYNC_BYTE_B   = 8'h33;
  localparam logic [7:0] CMD_DATA      = 8'h04;
  localparam logic [7:0] FLAG_COMPRESS = 8'h00;
  localparam logic [7:0] LEN_LOW       = 8'h80;
  localparam logic [7:0] LEN_HIGH      = 8'h02;
  localparam logic [7:0] PAD_BYTE      = 8'h00;

  // Checksum seed: command, flag and both length bytes.
  localparam logic [SUM_W-1:0] SUM_INIT =
    SUM_W'(CMD_DATA) + SUM_W'(FLAG_COMPRESS) + SUM_W'(LEN_LOW) + SUM_W'(LEN_HIGH);

  // Byte slots of one request's emission, in send order.
  typedef enum logic [3:0] {
    STEP_SYNC_A,
    STEP_SYNC_B,
    STEP_CMD,
    STEP_FLAG,
    STEP_LEN_LO,
    STEP_LEN_HI,
    STEP_DATA,
    STEP_SUM_LO,
    STEP_SUM_HI,
    STEP_PAD_A,
    STEP_PAD_B
  } step_t;

  // Per-request framing decision from the packet accounting.
  typedef struct packed {
    logic             hdr;
    logic             trl;
    logic [SUM_W-1:0] sum;
  } acct_t;

endpackage

`default_nettype wire

// ----- rtl/core/tile_data_packet_framer.sv -----
// Top level of the tile data packet framer.
// Usage:
//   Input channel (in_valid/in_ready/in_data_byte) takes one tile data byte per request.
//   Output channel (out_valid/out_ready/out_*) sends one serial byte per request.
//   The first byte of a packet emits the six-byte header and then the byte;
//   the 640th byte emits the byte, the checksum (low, high) and two zero pads.
//   All other bytes emit just themselves. out_run_last flags the final byte
//   caused by one input request, out_packet_done the final pad of a packet.
// Path: an accepted request is first staged, then its bytes load into the output register.
// Throughput: one output byte per cycle while out_ready is high, set by the
//   single output register and the byte sequencer. A plain data byte emits
//   one byte, a packet-opening byte seven, a packet-closing byte five: 650
//   output bytes per 640-byte packet. The next request is taken in the cycle
//   its predecessor's last byte moves to the output register.
// Reset: synchronous, active low; clears the position, checksum, sequencer
//   and output valid, so the next byte opens a new packet.
// Stall: when out_ready is low the output byte holds, the sequencer holds,
//   and in_ready drops once the staged request cannot drain.
`default_nettype none
`include "tile_data_packet_framer_defines.svh"

module tile_data_packet_framer
  import tdpf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_tx_byte,
  output logic            out_run_last,
  output logic            out_packet_done
);

  acct_t            acct;
  logic             in_fire;

  // Staged request and its sequencer.
  logic             st_valid_r, st_valid_nxt;
  logic [7:0]       st_data_r;
  logic             st_trl_r;
  logic [SUM_W-1:0] st_sum_r;
  step_t            st_step_r, st_step_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_tx_r;
  logic             out_last_r;
  logic             out_done_r;

  logic             load;
  logic             is_last;
  logic [7:0]       sel_byte;

  assign in_fire = in_valid && in_ready;

  tdpf_acct u_acct (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_fire),
    .data_byte (in_data_byte),
    .acct      (acct)
  );

  // Advance into the output register whenever it is empty or draining.
  assign load    = st_valid_r && (!out_valid_r || out_ready);
  assign is_last = st_trl_r ? (st_step_r == STEP_PAD_B) : (st_step_r == STEP_DATA);
  assign in_ready = !st_valid_r || (load && is_last);

  // Byte select for the current slot.
  always_comb begin
    unique case (st_step_r)
      STEP_SYNC_A: sel_byte = SYNC_BYTE_A;
      STEP_SYNC_B: sel_byte = SYNC_BYTE_B;
      STEP_CMD:    sel_byte = CMD_DATA;
      STEP_FLAG:   sel_byte = FLAG_COMPRESS;
      STEP_LEN_LO: sel_byte = LEN_LOW;
      STEP_LEN_HI: sel_byte = LEN_HIGH;
      STEP_DATA:   sel_byte = st_data_r;
      STEP_SUM_LO: sel_byte = st_sum_r[7:0];
      STEP_SUM_HI: sel_byte = st_sum_r[15:8];
      STEP_PAD_A:  sel_byte = PAD_BYTE;
      STEP_PAD_B:  sel_byte = PAD_BYTE;
      default:     sel_byte = PAD_BYTE;
    endcase
  end

  // Next slot: a new request starts at the header or the data byte,
  // otherwise step forward on each load.
  always_comb begin
    st_valid_nxt = st_valid_r;
    st_step_nxt  = st_step_r;
    if (in_fire) begin
      st_valid_nxt = 1'b1;
      st_step_nxt  = acct.hdr ? STEP_SYNC_A : STEP_DATA;
    end else if (load) begin
      if (is_last) begin
        st_valid_nxt = 1'b0;
      end else begin
        st_step_nxt = step_t'(st_step_r + 4'd1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r  <= 1'b0;
      st_step_r   <= STEP_DATA;
      out_valid_r <= 1'b0;
    end else begin
      st_valid_r  <= st_valid_nxt;
      st_step_r   <= st_step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on accept / load, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      st_data_r <= in_data_byte;
      st_trl_r  <= acct.trl;
      st_sum_r  <= acct.sum;
    end
    if (load) begin
      out_tx_r   <= sel_byte;
      out_last_r <= is_last;
      out_done_r <= is_last && st_trl_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tx_byte     = out_tx_r;
  assign out_run_last    = out_last_r;
  assign out_packet_done = out_done_r;

  `TDPF_ASSERT_NOW(a_done_is_last, clk, rst_n, out_valid_r && out_done_r, out_last_r,
    "packet_done without run_last")
  `TDPF_ASSERT_NOW(a_take_only_on_drain, clk, rst_n, st_valid_r && in_ready, load && is_last,
    "request taken while staged request still has bytes")
  `TDPF_ASSERT_NEXT(a_step_holds, clk, rst_n, st_valid_r && !load && !in_fire,
    $stable(st_step_r) && st_valid_r, "sequencer moved while stalled")
  `TDPF_ASSERT_NOW(a_step_range, clk, rst_n, st_valid_r,
    st_step_r == STEP_PAD_B || st_step_r < STEP_PAD_B, "sequencer slot out of range")

endmodule

`default_nettype wire

// ----- rtl/core/tdpf_acct.sv -----
// Packet position and running checksum bookkeeping.
`default_nettype none

module tdpf_acct
  import tdpf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  output acct_t           acct
);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [SUM_W-1:0] sum_r, sum_nxt, sum_base, sum_new;
  logic             hdr, trl;

  always_comb begin
    hdr      = (pos_r == '0);
    sum_base = hdr ? SUM_INIT : sum_r;
    sum_new  = sum_base + SUM_W'(data_byte);
    pos_inc  = pos_r + POS_W'(1);
    trl      = (pos_inc >= PKT_DATA_BYTES);
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    if (accept) begin
      pos_nxt = trl ? '0 : pos_inc;
      sum_nxt = trl ? '0 : sum_new;
    end
  end

  assign acct = '{hdr: hdr, trl: trl, sum: sum_new};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire
